>>> hdl/ecps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecps_pkg
// Shared types and constants of the elevator car plant step unit.
// ----------------------------------------------------------------------------
package ecps_pkg;

    localparam int MAX_FLOORS_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] REG_FLOOR_COUNT  = 2'd0;
    localparam logic [1:0] REG_FLOOR_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CAR_SPEED    = 2'd2;
    localparam logic [1:0] REG_SNAP_TOL     = 2'd3;

    // configuration reset values
    localparam logic [6:0]  FLOOR_COUNT_RST  = 7'd8;
    localparam logic [23:0] FLOOR_HEIGHT_RST = 24'd3000000;
    localparam logic [13:0] CAR_SPEED_RST    = 14'd1000;
    localparam logic [22:0] SNAP_TOL_RST     = 23'd50000;

    // motor command codes
    localparam logic [1:0] MC_STOP = 2'd0;
    localparam logic [1:0] MC_UP   = 2'd1;
    localparam logic [1:0] MC_DOWN = 2'd2;
    localparam logic [1:0] MC_HOLD = 2'd3;

    // motion codes
    localparam logic [1:0] MOT_STILL   = 2'd0;
    localparam logic [1:0] MOT_RISING  = 2'd1;
    localparam logic [1:0] MOT_FALLING = 2'd2;

    typedef struct packed {
        logic [6:0]  floor_count;
        logic [23:0] floor_height_um;
        logic [13:0] car_speed_um_per_ms;
        logic [22:0] snap_tolerance_um;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_MOVE,
        S_CLAMP,
        S_SNAP,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mult;
        logic move;
        logic clamp;
        logic snap_step;
        logic div_init;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic snap_on;
        logic snap_done;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> hdl/ecps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecps_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module ecps_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [23:0]   i_cfg_data,
    output ecps_pkg::t_cfg     o_cfg
);

    ecps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_count         <= ecps_pkg::FLOOR_COUNT_RST;
            r_cfg.floor_height_um     <= ecps_pkg::FLOOR_HEIGHT_RST;
            r_cfg.car_speed_um_per_ms <= ecps_pkg::CAR_SPEED_RST;
            r_cfg.snap_tolerance_um   <= ecps_pkg::SNAP_TOL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ecps_pkg::REG_FLOOR_COUNT:  r_cfg.floor_count         <= i_cfg_data[6:0];
                ecps_pkg::REG_FLOOR_HEIGHT: r_cfg.floor_height_um     <= i_cfg_data[23:0];
                ecps_pkg::REG_CAR_SPEED:    r_cfg.car_speed_um_per_ms <= i_cfg_data[13:0];
                ecps_pkg::REG_SNAP_TOL:     r_cfg.snap_tolerance_um   <= i_cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/ecps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecps_ctrl
// Step sequencer: accept, multiply, move, clamp, floor snap, divide, commit.
// ----------------------------------------------------------------------------
module ecps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire ecps_pkg::t_status i_sts,
    output ecps_pkg::t_cmd         o_cmd
);

    ecps_pkg::t_state r_state;
    ecps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ecps_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ecps_pkg::S_MULT;
                end
            end
            ecps_pkg::S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ecps_pkg::S_MOVE;
            end
            ecps_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = ecps_pkg::S_CLAMP;
            end
            ecps_pkg::S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = i_sts.snap_on ? ecps_pkg::S_SNAP : ecps_pkg::S_DIV_INIT;
            end
            ecps_pkg::S_SNAP: begin
                o_cmd.snap_step = 1'b1;
                if (i_sts.snap_done) begin
                    n_state = ecps_pkg::S_DIV_INIT;
                end
            end
            ecps_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ecps_pkg::S_DIV;
            end
            ecps_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ecps_pkg::S_DONE;
                end
            end
            ecps_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ecps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ecps_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/ecps_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecps_dpath
// Car state, position arithmetic, floor snap search, rounding divider and
// output register.
// ----------------------------------------------------------------------------
module ecps_dpath #(
    parameter int MAX_FLOORS = ecps_pkg::MAX_FLOORS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ecps_pkg::t_cmd  i_cmd,
    output ecps_pkg::t_status    o_sts,
    input  wire ecps_pkg::t_cfg  i_cfg,
    input  wire logic [15:0]     i_s_tdata,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [39:0]          o_m_tdata
);

    localparam int FLW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;  // floor index bits
    localparam int CW  = ($clog2(MAX_FLOORS + 1) > 7) ? $clog2(MAX_FLOORS + 1) : 7;
    localparam int TPW = FLW + 24;                                  // top position bits
    localparam int PW  = (TPW > 31) ? TPW : 31;                     // working position bits
    localparam int RW  = (25 + FLW > 32) ? 25 + FLW : 32;           // divider bits
    localparam int DCW = $clog2(FLW + 1);

    // input fields
    logic [9:0] in_tick;
    logic [1:0] in_motor;
    logic       in_door_open;
    logic       in_estop;
    logic       in_fault;

    assign in_tick      = i_s_tdata[9:0];
    assign in_motor     = i_s_tdata[11:10];
    assign in_door_open = i_s_tdata[12];
    assign in_estop     = i_s_tdata[13];
    assign in_fault     = i_s_tdata[14];

    // control state
    logic [29:0] r_pos_st;
    logic        r_door_flag;
    logic        r_out_valid;

    // working registers
    logic [9:0]      r_tick;
    logic [1:0]      r_motor;
    logic            r_door_open;
    logic [1:0]      r_motion;
    logic [23:0]     r_dist;
    logic [TPW-1:0]  r_top;
    logic [FLW-1:0]  r_fm1;
    logic [23:0]     r_h;
    logic [PW-1:0]   r_pos;
    logic [FLW-1:0]  r_f;
    logic [PW-1:0]   r_target;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_dsr;
    logic [FLW-1:0]  r_quo;
    logic [DCW-1:0]  r_dcnt;

    logic [29:0] r_out_pos;
    logic [5:0]  r_out_floor;
    logic [1:0]  r_out_motion;
    logic        r_out_door;

    // effective floor count and height
    logic [CW-1:0]  fc_ext;
    logic [CW-1:0]  floors_c;
    logic [FLW-1:0] fm1_c;
    logic [23:0]    h_c;

    always_comb begin
        fc_ext = CW'(i_cfg.floor_count);
        if (fc_ext == '0) begin
            floors_c = CW'(1);
        end else if (fc_ext > CW'(MAX_FLOORS)) begin
            floors_c = CW'(MAX_FLOORS);
        end else begin
            floors_c = fc_ext;
        end
        fm1_c = FLW'(floors_c - CW'(1));
        h_c   = (i_cfg.floor_height_um == '0) ? 24'd1 : i_cfg.floor_height_um;
    end

    logic [1:0] motion_c;

    always_comb begin
        motion_c = ecps_pkg::MOT_STILL;
        if (!in_estop && !in_fault && r_door_flag) begin
            if (in_motor == ecps_pkg::MC_UP) begin
                motion_c = ecps_pkg::MOT_RISING;
            end else if (in_motor == ecps_pkg::MC_DOWN) begin
                motion_c = ecps_pkg::MOT_FALLING;
            end
        end
    end

    logic [PW-1:0] pos_in;
    logic [PW-1:0] dist_ext;
    logic [PW-1:0] top_ext;
    logic [PW-1:0] snap_diff;
    logic          snap_hit;
    logic          div_ge;
    logic [FLW-1:0] floor_c;

    assign pos_in    = PW'(r_pos_st);
    assign dist_ext  = PW'(r_dist);
    assign top_ext   = PW'(r_top);
    assign snap_diff = (r_pos > r_target) ? (r_pos - r_target) : (r_target - r_pos);
    assign snap_hit  = snap_diff < PW'(i_cfg.snap_tolerance_um);
    assign div_ge    = r_rem >= r_dsr;
    assign floor_c   = (r_quo > r_fm1) ? r_fm1 : r_quo;

    // further floors only move away once the target passes the car
    assign o_sts.snap_on   = (r_motor == ecps_pkg::MC_STOP) || (r_motor == ecps_pkg::MC_HOLD);
    assign o_sts.snap_done = snap_hit || (r_target >= r_pos) || (r_f == r_fm1);
    assign o_sts.div_last  = (r_dcnt == '0);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_st    <= '0;
            r_door_flag <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pos_st    <= r_pos[29:0];
                r_door_flag <= !r_door_open;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tick      <= in_tick;
            r_motor     <= in_motor;
            r_door_open <= in_door_open;
            r_motion    <= motion_c;
        end
        if (i_cmd.mult) begin
            r_dist <= 24'(r_tick * i_cfg.car_speed_um_per_ms);
            r_top  <= TPW'(fm1_c * h_c);
            r_fm1  <= fm1_c;
            r_h    <= h_c;
        end
        if (i_cmd.move) begin
            case (r_motion)
                ecps_pkg::MOT_RISING: begin
                    r_pos <= pos_in + dist_ext;
                end
                ecps_pkg::MOT_FALLING: begin
                    if (dist_ext > pos_in) begin
                        r_pos    <= '0;
                        r_motion <= ecps_pkg::MOT_STILL;
                    end else begin
                        r_pos <= pos_in - dist_ext;
                    end
                end
                default: begin
                    r_pos <= pos_in;
                end
            endcase
        end
        if (i_cmd.clamp) begin
            if (r_pos > top_ext) begin
                r_pos    <= top_ext;
                r_motion <= ecps_pkg::MOT_STILL;
            end
            r_f      <= '0;
            r_target <= '0;
        end
        if (i_cmd.snap_step) begin
            if (snap_hit) begin
                r_pos <= r_target;
            end else begin
                r_f      <= r_f + FLW'(1);
                r_target <= r_target + PW'(r_h);
            end
        end
        if (i_cmd.div_init) begin
            // round half up: (2*pos + h) / (2*h)
            r_rem  <= RW'({r_pos[29:0], 1'b0}) + RW'(r_h);
            r_dsr  <= RW'({r_h, 1'b0}) << (FLW - 1);
            r_quo  <= '0;
            r_dcnt <= DCW'(FLW - 1);
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo  <= FLW'({r_quo, div_ge});
            r_dsr  <= r_dsr >> 1;
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.commit) begin
            r_out_pos    <= r_pos[29:0];
            r_out_floor  <= 6'(floor_c);
            r_out_motion <= r_motion;
            r_out_door   <= !r_door_open;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_door, r_out_motion, r_out_floor, r_out_pos};

endmodule
`default_nettype wire

>>> hdl/elevator_car_plant_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: load, multiply, move, clamp, floor snap search, divider init, then
// FLW = clog2(MAX_FLOORS) rounding divider steps (6 at 64 floors), then commit once the
// output is free; the floor snap search runs on stop and hold commands, not on up and down
// Flow: one item at a time, the next tick is taken in the cycle after the result is
// loaded into the output register
// Reset (synchronous, active low): car at ground floor, door closed, registers default
// ----------------------------------------------------------------------------
// elevator_car_plant_step_unit
// Plant model of an elevator car, advanced by one tick transaction.
// ----------------------------------------------------------------------------
module elevator_car_plant_step_unit #(
    parameter int MAX_FLOORS = ecps_pkg::MAX_FLOORS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tick_ms[9:0], motor_command[11:10], door_open_command[12],
    // emergency_stop[13], drive_fault[14], zero[15]
    input  wire logic [15:0] i_s_tdata,
    // result channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // car_position_um[29:0], car_floor[35:30], car_motion[37:36],
    // door_closed_sensor[38], zero[39]
    output logic [39:0]      o_m_tdata,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    ecps_pkg::t_cfg    cfg;
    ecps_pkg::t_cmd    cmd;
    ecps_pkg::t_status sts;

    ecps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ecps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ecps_dpath #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg      (cfg),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

>>> hdl/ecps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecps_checker
// Port-level checks of the elevator car plant step unit, bound to the top.
// ----------------------------------------------------------------------------
module ecps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

    // one item at a time: no second transaction straight after the first
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("tick taken while previous step still at work");

    // motion code three is never produced
    a_motion_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[37:36] != 2'd3))
        else $error("invalid motion code");

    // a new result is loaded only while a tick is in progress
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared with no tick in progress");

endmodule

bind elevator_car_plant_step_unit ecps_checker u_ecps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
